FILE: rtl/core/annexb_pkg.sv
// Types, codes and the per-byte NAL emit function for the Annex B splitter.
package annexb_pkg;

   localparam logic [4:0]  NAL_TYPE_AUD     = 5'd9;
   localparam logic [4:0]  NAL_TYPE_END_SEQ = 5'd10;
   localparam logic [7:0]  NAL_INDEX_MAX    = 8'hFF;
   localparam logic [15:0] AU_INDEX_MAX     = 16'hFFFF;
   localparam int          HELD_DEPTH       = 3;
   localparam int          RSP_DEPTH        = 4;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        nal_first;
      logic        nal_end;
      logic [4:0]  nal_type;
      logic [1:0]  ref_idc;
      logic        forbidden_bit;
      logic        au_first;
      logic [7:0]  nal_index;
      logic [15:0] au_index;
   } rsp_word_type;

   typedef struct packed {
      logic        in_nal;
      logic        expect_header;
      logic [7:0]  current_header;
      logic [7:0]  nal_counter;
      logic [15:0] au_counter;
      logic        nal_seen;
   } nal_state_type;

   typedef struct packed {
      nal_state_type st;
      logic          valid;
      rsp_word_type  rsp;
   } put_type;

   localparam nal_state_type NAL_STATE_RESET = '{
      in_nal: 1'b0, expect_header: 1'b0, current_header: 8'd0,
      nal_counter: 8'd0, au_counter: 16'd0, nal_seen: 1'b0};

   function automatic put_type put_byte(nal_state_type st, logic [7:0] b, logic is_end);
      put_type    p;
      logic [4:0] t;
      logic [4:0] ct;
      p       = '0;
      p.st    = st;
      p.valid = st.in_nal;
      t       = b[4:0];
      if (st.in_nal && st.expect_header) begin
         p.rsp.nal_first         = 1'b1;
         p.st.expect_header      = 1'b0;
         p.st.current_header     = b;
         if (t == NAL_TYPE_AUD || t == NAL_TYPE_END_SEQ) begin
            if (st.au_counter != AU_INDEX_MAX) begin
               p.st.au_counter = st.au_counter + 16'd1;
            end
            p.st.nal_counter = 8'd0;
         end else if (st.nal_seen && st.nal_counter != NAL_INDEX_MAX) begin
            p.st.nal_counter = st.nal_counter + 8'd1;
         end
         p.st.nal_seen = 1'b1;
      end
      ct                  = p.st.current_header[4:0];
      p.rsp.payload_byte  = b;
      p.rsp.nal_end       = is_end;
      p.rsp.nal_type      = ct;
      p.rsp.ref_idc       = p.st.current_header[6:5];
      p.rsp.forbidden_bit = p.st.current_header[7];
      p.rsp.au_first      = (ct == NAL_TYPE_AUD) || (ct == NAL_TYPE_END_SEQ);
      p.rsp.nal_index     = p.st.nal_counter;
      p.rsp.au_index      = p.st.au_counter;
      return p;
   endfunction

endpackage

FILE: rtl/core/annexb_nal_access_unit_splitter.sv
// Top level of the Annex B start code parser and NAL / access unit splitter.
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_ready  | data_byte, stream_end
//   rsp     | out | rsp_valid/rsp_ready  | payload byte, NAL marks, header fields, indices
//
// One byte is taken per cycle while the buffer is empty or its last word leaves; a
// payload byte leaves three bytes after it arrives. A byte marked stream_end loads up
// to four words, drained one per cycle; the next byte goes in the cycle the last leaves.
// Synchronous active-high reset clears the parse state and empties the buffer.
// rsp stalls hold the buffer and block req until its last word leaves.
module annexb_nal_access_unit_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_nal_first,
   output logic        rsp_nal_end,
   output logic [4:0]  rsp_nal_type,
   output logic [1:0]  rsp_ref_idc,
   output logic        rsp_forbidden_bit,
   output logic        rsp_au_first,
   output logic [7:0]  rsp_nal_index,
   output logic [15:0] rsp_au_index,
   output logic        rsp_last
);
   import annexb_pkg::*;

   logic [7:0]    held_ff [HELD_DEPTH];
   logic [7:0]    held_in [HELD_DEPTH];
   logic [1:0]    held_count_ff, held_count_in, held_count_step;
   nal_state_type nal_state_ff, nal_state_in, st_step;
   rsp_word_type  rsp_buf_ff [RSP_DEPTH];
   rsp_word_type  rsp_buf_in [RSP_DEPTH];
   logic [2:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]    rsp_idx_ff, rsp_idx_in;
   logic [7:0]    held_step [HELD_DEPTH];

   logic          req_fire, rsp_fire;
   logic          z0, z1, z2, is_one, is_zero;
   logic          start4, start3, trail, emit0, v0;
   logic [1:0]    flush_n;
   put_type       p0, f1, f2, f3;
   rsp_word_type  rsp_word;

   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_cnt_ff != 3'd0;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (rsp_cnt_ff == 3'd0) || (rsp_cnt_ff == 3'd1 && rsp_ready);

   assign z0      = held_ff[0] == 8'd0;
   assign z1      = held_ff[1] == 8'd0;
   assign z2      = held_ff[2] == 8'd0;
   assign is_one  = req_data_byte == 8'd1;
   assign is_zero = req_data_byte == 8'd0;
   assign start4  = held_count_ff == 2'd3 && z0 && z1 && z2 && is_one;
   assign start3  = !start4 && is_one &&
                    ((held_count_ff == 2'd2 && z0 && z1) || (held_count_ff == 2'd3 && z1 && z2));
   assign trail   = held_count_ff == 2'd3 && z1 && z2 && is_zero;
   assign emit0   = held_count_ff == 2'd3 && !start4;

   // advance the parse for one byte: normal step, then flush on stream end
   always_comb begin
      p0              = put_byte(nal_state_ff, held_ff[0], start3 || trail);
      v0              = emit0 && p0.valid;
      st_step         = emit0 ? p0.st : nal_state_ff;
      held_step       = held_ff;
      held_count_step = held_count_ff;
      if (start4 || start3) begin
         st_step.in_nal        = 1'b1;
         st_step.expect_header = 1'b1;
         held_count_step       = 2'd0;
      end else if (trail) begin
         st_step.in_nal        = 1'b0;
         st_step.expect_header = 1'b0;
         held_step[0]          = held_ff[1];
         held_step[1]          = held_ff[2];
         held_step[2]          = req_data_byte;
         held_count_step       = 2'd3;
      end else if (held_count_ff == 2'd3) begin
         held_step[0]          = held_ff[1];
         held_step[1]          = held_ff[2];
         held_step[2]          = req_data_byte;
         held_count_step       = 2'd3;
      end else begin
         held_step[held_count_ff] = req_data_byte;
         held_count_step          = held_count_ff + 2'd1;
      end
      f1      = put_byte(st_step, held_step[0], held_count_step == 2'd1);
      f2      = put_byte(f1.st, held_step[1], held_count_step == 2'd2);
      f3      = put_byte(f2.st, held_step[2], held_count_step == 2'd3);
      flush_n = (req_stream_end && st_step.in_nal) ? held_count_step : 2'd0;
   end

   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      nal_state_in  = nal_state_ff;
      rsp_buf_in    = rsp_buf_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_idx_in    = rsp_idx_ff;
      if (rsp_fire) begin
         rsp_cnt_in = rsp_cnt_ff - 3'd1;
         rsp_idx_in = rsp_idx_ff + 2'd1;
      end
      if (req_fire) begin
         if (req_stream_end) begin
            held_in       = '{default: 8'd0};
            held_count_in = 2'd0;
            nal_state_in  = NAL_STATE_RESET;
         end else begin
            held_in       = held_step;
            held_count_in = held_count_step;
            nal_state_in  = st_step;
         end
         if (v0) begin
            rsp_buf_in = '{p0.rsp, f1.rsp, f2.rsp, f3.rsp};
         end else begin
            rsp_buf_in = '{f1.rsp, f2.rsp, f3.rsp, f3.rsp};
         end
         rsp_cnt_in = {2'b00, v0} + {1'b0, flush_n};
         rsp_idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         nal_state_ff  <= NAL_STATE_RESET;
         rsp_cnt_ff    <= 3'd0;
         rsp_idx_ff    <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
         nal_state_ff  <= nal_state_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_idx_ff    <= rsp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff    <= held_in;
      rsp_buf_ff <= rsp_buf_in;
   end

   assign rsp_word          = rsp_buf_ff[rsp_idx_ff];
   assign rsp_payload_byte  = rsp_word.payload_byte;
   assign rsp_nal_first     = rsp_word.nal_first;
   assign rsp_nal_end       = rsp_word.nal_end;
   assign rsp_nal_type      = rsp_word.nal_type;
   assign rsp_ref_idc       = rsp_word.ref_idc;
   assign rsp_forbidden_bit = rsp_word.forbidden_bit;
   assign rsp_au_first      = rsp_word.au_first;
   assign rsp_nal_index     = rsp_word.nal_index;
   assign rsp_au_index      = rsp_word.au_index;
   assign rsp_last          = rsp_cnt_ff == 3'd1;

`ifndef SYNTHESIS
   a_rsp_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff <= 3'd4)
      else $error("result buffer count out of range");

   a_ready_near_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> rsp_cnt_ff <= 3'd1)
      else $error("req taken while buffer holds more than one word");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_stream_end |=> held_count_ff == 2'd0 && !nal_state_ff.in_nal)
      else $error("stream end did not clear parse state");

   a_au_start_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nal_first && rsp_au_first |-> rsp_nal_index == 8'd0)
      else $error("access unit delimiter word with nonzero NAL index");
`endif

endmodule

FILE: bench/tb_annexb_nal_access_unit_splitter.sv
// Self-checking bench for the Annex B splitter: byte streams in, checked NAL words out.
module tb_annexb_nal_access_unit_splitter;
   import annexb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct packed {
      rsp_word_type word;
      logic         last;
   } nal_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_nal_first;
   logic        rsp_nal_end;
   logic [4:0]  rsp_nal_type;
   logic [1:0]  rsp_ref_idc;
   logic        rsp_forbidden_bit;
   logic        rsp_au_first;
   logic [7:0]  rsp_nal_index;
   logic [15:0] rsp_au_index;
   logic        rsp_last;

   annexb_nal_access_unit_splitter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_nal_first     (rsp_nal_first),
      .rsp_nal_end       (rsp_nal_end),
      .rsp_nal_type      (rsp_nal_type),
      .rsp_ref_idc       (rsp_ref_idc),
      .rsp_forbidden_bit (rsp_forbidden_bit),
      .rsp_au_first      (rsp_au_first),
      .rsp_nal_index     (rsp_nal_index),
      .rsp_au_index      (rsp_au_index),
      .rsp_last          (rsp_last)
   );

   always #1 clock = ~clock;

   int           req_gap_max = 12;
   int           rsp_gap_max = 12;
   int           fails = 0;
   int           idle_cycles = 0;
   nal_byte_type expected_nal_bytes[$];
   nal_byte_type step_bytes[$];
   nal_byte_type oldest;
   logic [7:0]   stream_q[$];

   // splitter state mirror
   logic [7:0]  look_bytes[3];
   int          look_count;
   logic        in_nal;
   logic        want_header;
   logic        header_seen;
   logic [7:0]  cur_header;
   logic [7:0]  nal_count;
   logic [15:0] au_count;

   function automatic void clear_splitter();
      look_bytes  = '{8'h00, 8'h00, 8'h00};
      look_count  = 0;
      in_nal      = 1'b0;
      want_header = 1'b0;
      header_seen = 1'b0;
      cur_header  = 8'h00;
      nal_count   = 8'h00;
      au_count    = 16'h0000;
   endfunction

   function automatic void emit_nal_byte(logic [7:0] b, logic is_end);
      nal_byte_type w;
      logic [4:0]   t;
      if (!in_nal || step_bytes.size() >= RSP_DEPTH) return;
      w = '0;
      t = b[4:0];
      if (want_header) begin
         w.word.nal_first = 1'b1;
         want_header      = 1'b0;
         cur_header       = b;
         if (t == NAL_TYPE_AUD || t == NAL_TYPE_END_SEQ) begin
            if (au_count != AU_INDEX_MAX) au_count = au_count + 16'd1;
            nal_count = 8'h00;
         end else if (header_seen && nal_count != NAL_INDEX_MAX) begin
            nal_count = nal_count + 8'd1;
         end
         header_seen = 1'b1;
      end
      w.word.payload_byte  = b;
      w.word.nal_end       = is_end;
      w.word.nal_type      = cur_header[4:0];
      w.word.ref_idc       = cur_header[6:5];
      w.word.forbidden_bit = cur_header[7];
      w.word.au_first      = (cur_header[4:0] == NAL_TYPE_AUD) ||
                             (cur_header[4:0] == NAL_TYPE_END_SEQ);
      w.word.nal_index     = nal_count;
      w.word.au_index      = au_count;
      step_bytes.push_back(w);
   endfunction

   function automatic void shift_look();
      look_bytes[0] = look_bytes[1];
      look_bytes[1] = look_bytes[2];
      look_bytes[2] = 8'h00;
      if (look_count > 0) look_count--;
   endfunction

   function automatic void parse_stream_byte(logic [7:0] b, logic fin);
      int c;
      c = look_count;
      step_bytes.delete();
      if (c == 3 && look_bytes[0] == 8'h00 && look_bytes[1] == 8'h00 &&
          look_bytes[2] == 8'h00 && b == 8'h01) begin
         look_count  = 0;
         in_nal      = 1'b1;
         want_header = 1'b1;
      end else if (c >= 2 && look_bytes[c-2] == 8'h00 && look_bytes[c-1] == 8'h00 &&
                   b == 8'h01) begin
         if (c == 3) emit_nal_byte(look_bytes[0], 1'b1);
         look_count  = 0;
         in_nal      = 1'b1;
         want_header = 1'b1;
      end else if (c == 3 && look_bytes[1] == 8'h00 && look_bytes[2] == 8'h00 &&
                   b == 8'h00) begin
         emit_nal_byte(look_bytes[0], 1'b1);
         in_nal      = 1'b0;
         want_header = 1'b0;
         shift_look();
         look_bytes[2] = b;
         look_count    = 3;
      end else begin
         if (c == 3) begin
            emit_nal_byte(look_bytes[0], 1'b0);
            shift_look();
            c = 2;
         end
         look_bytes[c] = b;
         look_count    = c + 1;
      end
      if (fin) begin
         c = look_count;
         for (int i = 0; i < c; i++) emit_nal_byte(look_bytes[i], i + 1 == c);
         clear_splitter();
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
      foreach (step_bytes[i]) expected_nal_bytes.push_back(step_bytes[i]);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_nal_bytes.size() == 0) begin
            $error("word with no expectation: payload_byte %0d", rsp_payload_byte);
            fails++;
         end else begin
            oldest = expected_nal_bytes.pop_front();
            check_field("payload_byte", oldest.word.payload_byte, rsp_payload_byte);
            check_field("nal_first", oldest.word.nal_first, rsp_nal_first);
            check_field("nal_end", oldest.word.nal_end, rsp_nal_end);
            check_field("nal_type", oldest.word.nal_type, rsp_nal_type);
            check_field("ref_idc", oldest.word.ref_idc, rsp_ref_idc);
            check_field("forbidden_bit", oldest.word.forbidden_bit, rsp_forbidden_bit);
            check_field("au_first", oldest.word.au_first, rsp_au_first);
            check_field("nal_index", oldest.word.nal_index, rsp_nal_index);
            check_field("au_index", oldest.word.au_index, rsp_au_index);
            check_field("last", oldest.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : rsp_side
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_stream_end <= fin;
      do @(posedge clock); while (!req_ready);
      parse_stream_byte(b, fin);
   endtask

   task automatic send_stream(input logic fin_last);
      int n;
      n = stream_q.size();
      for (int i = 0; i < n; i++) send_byte(stream_q[i], fin_last && (i == n - 1));
      stream_q.delete();
   endtask

   function automatic void load_hex(string s);
      byte        ch;
      logic [7:0] acc;
      int         half;
      acc  = 8'h00;
      half = 0;
      for (int i = 0; i < s.len(); i++) begin
         ch = s.getc(i);
         if (ch != " ") begin
            acc = {acc[3:0], (ch >= "a") ? 4'(ch - "a" + 10) : 4'(ch - "0")};
            half++;
            if (half == 2) begin
               stream_q.push_back(acc);
               half = 0;
            end
         end
      end
   endfunction

   task automatic send_hex(input string s, input logic fin_last);
      load_hex(s);
      send_stream(fin_last);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_nal_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0, 1, 2: return 8'h00;
         3:       return 8'h01;
         4:       return 8'h03;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_leading_junk();
      send_hex("ff 01 7e 00 01 00 00 01 67 42 00 1f 00 00 01 68 ce", 1'b1);
   endtask

   task automatic test_header_extremes();
      send_hex("00 00 00 01 ff 00 ff 00 00 00 01 00 ff 80 7f", 1'b1);
      send_hex("00 00 01 e0 55 aa 00 00 01 1f 00", 1'b1);
   endtask

   task automatic test_empty_nal();
      send_hex("00 00 01 00 00 01 65 11 00 00 00 01 00 00 01 41 22", 1'b1);
   endtask

   task automatic test_three_zeros();
      send_hex("00 00 01 65 aa bb 00 00 00 00 cc dd 00 00 01 41 33 00 00 00", 1'b1);
      send_hex("00 00 01 41 01 00 00", 1'b1);
   endtask

   task automatic test_code_at_end();
      send_hex("00 00 01 65 77 00 00 01", 1'b1);
      send_hex("00 00 01 09 10 00 00 00 01", 1'b1);
      send_hex("00 00 01", 1'b1);
   endtask

   task automatic test_access_units();
      send_hex("00 00 01 06 05 00 00 01 67 00 00 01 09 f0 00 00 01 67 00 00 01 68", 1'b0);
      wait_drained();
      send_hex("00 00 01 0a 00 00 01 65 88 99 00 00 01 e9 00 00 01 2a 03", 1'b1);
   endtask

   task automatic test_random_streams();
      int         sent;
      int         len;
      logic [2:0] hi;
      logic [7:0] hdr;
      sent = 0;
      while (sent < 50) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 10);
            repeat (len) stream_q.push_back(noise_byte());
         end else begin
            repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 1) stream_q.push_back(8'h00);
               load_hex("00 00 01");
               hi = 3'($urandom_range(0, 7));
               case ($urandom_range(0, 3))
                  0:       hdr = {hi, NAL_TYPE_AUD};
                  1:       hdr = {hi, NAL_TYPE_END_SEQ};
                  default: hdr = 8'($urandom_range(0, 255));
               endcase
               stream_q.push_back(hdr);
               len = $urandom_range(0, 8);
               repeat (len) stream_q.push_back(noise_byte());
               if ($urandom_range(0, 5) == 0) begin
                  repeat ($urandom_range(1, 3)) stream_q.push_back(8'h00);
               end
            end
         end
         sent += stream_q.size();
         send_stream($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
      send_byte(8'h00, 1'b1);
      req_gap_max = 12;
      rsp_gap_max = 12;
   endtask

   initial begin
      clear_splitter();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_leading_junk();
      test_header_extremes();
      test_empty_nal();
      test_three_zeros();
      test_code_at_end();
      test_access_units();
      test_random_streams();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
